// File: rtl/chse_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash set engine package
// Shared widths, operation and status codes, default sizes and the state type
// of the engine's sequencer.
// ----------------------------------------------------------------------------
package chse_pkg;

  localparam int BUCKETS_DEF      = 10;
  localparam int BUCKET_DEPTH_DEF = 8;

  localparam int REQ_W    = 2;
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;
  localparam int BUCKET_W = 4;
  localparam int COUNT_W  = 4;

  localparam logic [REQ_W-1:0] OP_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [REQ_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_FRD,
    S_FGET,
    S_SCAN,
    S_SHIFT,
    S_UPD
  } chse_state_t;

endpackage

// File: rtl/chse_if.sv
// ----------------------------------------------------------------------------
// Chained hash set engine channels
// Request and result channels, each carrying valid, ready and one word.
// ----------------------------------------------------------------------------
interface chse_in_if;
  logic                        valid;
  logic                        ready;
  logic [chse_pkg::REQ_W-1:0]  req_type;
  logic [chse_pkg::KEY_W-1:0]  key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink (input valid, input req_type, input key, output ready);
endinterface

interface chse_out_if;
  logic                          valid;
  logic                          ready;
  logic [chse_pkg::STATUS_W-1:0] status;
  logic [chse_pkg::BUCKET_W-1:0] bucket;
  logic [chse_pkg::COUNT_W-1:0]  match_count;

  modport source (output valid, output status, output bucket, output match_count,
                  input ready);
  modport sink (input valid, input status, input bucket, input match_count,
                output ready);
endinterface

// File: rtl/chse_rem.sv
// ----------------------------------------------------------------------------
// Key remainder unit
// Works out key modulo the bucket count: the key is multiplied
// by a fixed-point reciprocal of the bucket count to give the quotient, and
// the remainder is then taken from the low bits of key minus quotient times
// the bucket count.
// ----------------------------------------------------------------------------
module chse_rem #(
  parameter int BUCKETS = chse_pkg::BUCKETS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [chse_pkg::KEY_W-1:0] key,
  output logic                       done,
  output logic [$clog2(BUCKETS)-1:0] rem
);

  localparam int RW  = $clog2(BUCKETS);
  localparam int KW  = chse_pkg::KEY_W;
  localparam int MCW = KW + 1;
  localparam int SH  = KW + RW;
  localparam int PW  = KW + MCW;
  localparam int QW  = PW - SH;
  localparam logic [MCW-1:0] RECIP = MCW'(((64'd1 << SH) / 64'(BUCKETS)) + 64'd1);

  logic [QW-1:0] quot;
  logic [QW-1:0] q_r;
  logic [RW-1:0] klo_r;
  logic [RW-1:0] qb;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] rem_nxt;
  logic          v_r;
  logic          done_r;

  assign quot    = QW'((PW'(key) * PW'(RECIP)) >> SH);
  assign qb      = q_r[RW-1:0] * RW'(BUCKETS);
  assign rem_nxt = klo_r - qb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v_r    <= start;
      done_r <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= quot;
      klo_r <= key[RW-1:0];
    end
    if (v_r) begin
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: rtl/chained_hash_set_engine.sv
// ----------------------------------------------------------------------------
// Chained hash set engine
// Every request passes the key remainder, the bucket fill read and a scan of
// the bucket's keys before its result word; a delete that finds its key then
// closes the gap. A stalled result word holds back the next result until taken.
// One request at a time, the next taken in the cycle after the result is
// registered; after the key remainder the scan reads one entry per cycle.
// Reset clears every bucket fill count at once; entry memory is not cleared.
// ----------------------------------------------------------------------------
module chained_hash_set_engine #(
  parameter int BUCKETS      = chse_pkg::BUCKETS_DEF,
  parameter int BUCKET_DEPTH = chse_pkg::BUCKET_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  chse_in_if.sink           in_if,
  chse_out_if.source        out_if
);

  localparam int ENTRIES = BUCKETS * BUCKET_DEPTH;
  localparam int BW      = $clog2(BUCKETS);
  localparam int AW      = $clog2(ENTRIES);
  localparam int CW      = $clog2(BUCKET_DEPTH + 1);
  localparam int MW      = (CW > chse_pkg::COUNT_W) ? CW : chse_pkg::COUNT_W;
  localparam int BXW     = (BW > chse_pkg::BUCKET_W) ? BW : chse_pkg::BUCKET_W;

  chse_pkg::chse_state_t state_r, state_nxt;

  logic [chse_pkg::REQ_W-1:0]    op_r, op_nxt;
  logic [chse_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [BW-1:0]                 bkt_r, bkt_nxt;
  logic [AW-1:0]                 base_r, base_nxt;
  logic [CW-1:0]                 fill_r, fill_nxt;
  logic [CW-1:0]                 idx_r, idx_nxt;
  logic                          rv_r, rv_nxt;
  logic [CW-1:0]                 ri_r, ri_nxt;
  logic [CW-1:0]                 match_r, match_nxt;
  logic                          found_r, found_nxt;
  logic [CW-1:0]                 first_r, first_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [chse_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [chse_pkg::BUCKET_W-1:0] out_bucket_r, out_bucket_nxt;
  logic [chse_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic [chse_pkg::KEY_W-1:0] ent_mem [ENTRIES];
  logic [chse_pkg::KEY_W-1:0] ent_q_r;
  logic [AW-1:0]              ent_raddr;
  logic                       ent_we;
  logic [AW-1:0]              ent_waddr;
  logic [chse_pkg::KEY_W-1:0] ent_wdata;

  logic [CW-1:0]      fill_mem [BUCKETS];
  logic [BUCKETS-1:0] fill_vld_r;
  logic [CW-1:0]      fill_q_r;
  logic               fill_qv_r;
  logic               fill_we;
  logic [CW-1:0]      fill_wdata;

  logic          in_acc;
  logic          rem_done;
  logic [BW-1:0] rem_val;
  logic          issue;
  logic          hit;
  logic [MW-1:0] match_ext;
  logic [BXW-1:0] bkt_ext;

  assign in_acc = in_if.valid && in_if.ready;

  chse_rem #(
    .BUCKETS (BUCKETS)
  ) u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .key   (in_if.key),
    .done  (rem_done),
    .rem   (rem_val)
  );

  assign ent_raddr = base_r + AW'(idx_r);
  assign issue     = (idx_r < fill_r);
  assign hit       = rv_r && (ent_q_r == key_r);
  assign match_ext = MW'(match_r);
  assign bkt_ext   = BXW'(bkt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chse_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    bkt_nxt        = bkt_r;
    base_nxt       = base_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    rv_nxt         = 1'b0;
    ri_nxt         = idx_r;
    match_nxt      = match_r;
    found_nxt      = found_r;
    first_nxt      = first_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_bucket_nxt = out_bucket_r;
    out_count_nxt  = out_count_r;
    ent_we         = 1'b0;
    ent_waddr      = base_r + AW'(fill_r);
    ent_wdata      = key_r;
    fill_we        = 1'b0;
    fill_wdata     = fill_r;
    in_if.ready    = 1'b0;

    case (state_r)
      chse_pkg::S_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          op_nxt    = in_if.req_type;
          key_nxt   = in_if.key;
          state_nxt = chse_pkg::S_MOD;
        end
      end
      chse_pkg::S_MOD: begin
        if (rem_done) begin
          bkt_nxt   = rem_val;
          state_nxt = chse_pkg::S_FRD;
        end
      end
      chse_pkg::S_FRD: begin
        base_nxt  = AW'(int'(bkt_r) * BUCKET_DEPTH);
        state_nxt = chse_pkg::S_FGET;
      end
      chse_pkg::S_FGET: begin
        fill_nxt  = fill_qv_r ? fill_q_r : '0;
        idx_nxt   = '0;
        match_nxt = '0;
        found_nxt = 1'b0;
        first_nxt = '0;
        state_nxt = chse_pkg::S_SCAN;
      end
      chse_pkg::S_SCAN: begin
        rv_nxt = issue;
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (hit) begin
          match_nxt = match_r + 1'b1;
          if (!found_r) begin
            found_nxt = 1'b1;
            first_nxt = ri_r;
          end
        end
        if (!issue && !rv_r) begin
          if (op_r == chse_pkg::OP_DELETE && found_r) begin
            idx_nxt   = first_r + 1'b1;
            state_nxt = chse_pkg::S_SHIFT;
          end else begin
            state_nxt = chse_pkg::S_UPD;
          end
        end
      end
      chse_pkg::S_SHIFT: begin
        rv_nxt = issue;
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (rv_r) begin
          ent_we    = 1'b1;
          ent_waddr = base_r + AW'(ri_r) - 1'b1;
          ent_wdata = ent_q_r;
        end
        if (!issue && !rv_r) begin
          state_nxt = chse_pkg::S_UPD;
        end
      end
      chse_pkg::S_UPD: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_bucket_nxt = bkt_ext[chse_pkg::BUCKET_W-1:0];
          out_count_nxt  = (match_ext > MW'(chse_pkg::COUNT_MAX)) ?
                           chse_pkg::COUNT_MAX : match_ext[chse_pkg::COUNT_W-1:0];
          state_nxt      = chse_pkg::S_IDLE;
          case (op_r)
            chse_pkg::OP_INSERT: begin
              if (fill_r == CW'(BUCKET_DEPTH)) begin
                out_status_nxt = chse_pkg::ST_FULL;
              end else begin
                ent_we         = 1'b1;
                fill_we        = 1'b1;
                fill_wdata     = fill_r + 1'b1;
                out_status_nxt = chse_pkg::ST_DONE;
              end
            end
            chse_pkg::OP_DELETE: begin
              if (found_r) begin
                fill_we        = 1'b1;
                fill_wdata     = fill_r - 1'b1;
                out_status_nxt = chse_pkg::ST_DONE;
              end else begin
                out_status_nxt = chse_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              out_status_nxt = (match_r != '0) ? chse_pkg::ST_DONE : chse_pkg::ST_NOT_FOUND;
            end
          endcase
        end
      end
      default: begin
        state_nxt = chse_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
      fill_vld_r  <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      rv_r        <= rv_nxt;
      if (fill_we) begin
        fill_vld_r[bkt_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    bkt_r        <= bkt_nxt;
    base_r       <= base_nxt;
    fill_r       <= fill_nxt;
    idx_r        <= idx_nxt;
    ri_r         <= ri_nxt;
    match_r      <= match_nxt;
    found_r      <= found_nxt;
    first_r      <= first_nxt;
    out_status_r <= out_status_nxt;
    out_bucket_r <= out_bucket_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_q_r <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[bkt_r] <= fill_wdata;
    end
    fill_q_r  <= fill_mem[bkt_r];
    fill_qv_r <= fill_vld_r[bkt_r];
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.bucket      = out_bucket_r;
  assign out_if.match_count = out_count_r;

  a_rem_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> state_r == chse_pkg::S_MOD)
    else $error("remainder finished outside the remainder wait");

  a_shift_found: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == chse_pkg::S_SHIFT |-> found_r && op_r == chse_pkg::OP_DELETE)
    else $error("gap closing without a matching key");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == chse_pkg::S_SCAN |-> fill_r <= CW'(BUCKET_DEPTH))
    else $error("bucket fill beyond depth");

  a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == chse_pkg::S_UPD |-> match_r <= fill_r)
    else $error("more matches than stored keys");

endmodule

// File: tb/chse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash set engine checker
// Watches the request and result channels, keeps its own copy of the bucket
// chains, works out the reply to every accepted request word and compares
// each accepted result word with the oldest reply still owed.
// ----------------------------------------------------------------------------
module chse_checker #(
  parameter int BUCKETS      = chse_pkg::BUCKETS_DEF,
  parameter int BUCKET_DEPTH = chse_pkg::BUCKET_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  chse_in_if   in_ch,
  chse_out_if  out_ch,
  output int   mismatches,
  output int   awaiting,
  output int   words_checked,
  output int   refusals
);
  import chse_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BUCKET_W-1:0] bucket;
    logic [COUNT_W-1:0]  match_count;
  } reply_t;

  logic [KEY_W-1:0] chain_key [BUCKETS][BUCKET_DEPTH];
  int unsigned      chain_fill [BUCKETS];
  reply_t           chain_replies [$];

  function automatic reply_t chain_apply(logic [REQ_W-1:0] op, logic [KEY_W-1:0] key);
    int unsigned b;
    int unsigned fill;
    int unsigned hits;
    int unsigned first;
    reply_t      r;
    b     = key % BUCKETS;
    fill  = chain_fill[b];
    hits  = 0;
    first = fill;
    for (int i = 0; i < fill; i++) begin
      if (chain_key[b][i] == key) begin
        hits++;
        if (first == fill) first = i;
      end
    end
    r.status = (hits > 0) ? ST_DONE : ST_NOT_FOUND;
    if (op == OP_INSERT) begin
      if (fill >= BUCKET_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        chain_key[b][fill] = key;
        chain_fill[b]      = fill + 1;
        r.status           = ST_DONE;
      end
    end else if (op == OP_DELETE && first < fill) begin
      // The oldest copy goes and the keys behind it close up.
      for (int i = first; i + 1 < fill; i++) chain_key[b][i] = chain_key[b][i + 1];
      chain_fill[b] = fill - 1;
    end
    r.bucket      = BUCKET_W'(b);
    r.match_count = (hits > COUNT_MAX) ? COUNT_MAX : COUNT_W'(hits);
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    int     errs;
    errs = 0;
    if (!rst_n) begin
      for (int b = 0; b < BUCKETS; b++) chain_fill[b] = 0;
      chain_replies.delete();
      mismatches    <= 0;
      awaiting      <= 0;
      words_checked <= 0;
      refusals      <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        want = chain_apply(in_ch.req_type, in_ch.key);
        if (want.status == ST_FULL) refusals <= refusals + 1;
        chain_replies.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.status, out_ch.bucket, out_ch.match_count};
        words_checked <= words_checked + 1;
        if (chain_replies.size() == 0) begin
          $display("%0t: unrequested result word: status %0d bucket %0d count %0d",
                   $time, got.status, got.bucket, got.match_count);
          errs++;
        end else begin
          want = chain_replies.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
            errs++;
          end
          if (got.bucket != want.bucket) begin
            $display("%0t: bucket expected %0d, actual %0d", $time, want.bucket, got.bucket);
            errs++;
          end
          if (got.match_count != want.match_count) begin
            $display("%0t: match count expected %0d, actual %0d",
                     $time, want.match_count, got.match_count);
            errs++;
          end
        end
      end
      mismatches <= mismatches + errs;
      awaiting   <= chain_replies.size();
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash set engine testbench
// Sends a directed opening of request words and then phases that fill, mix
// and drain the buckets with keys drawn mostly from a small pool, with random
// gaps on both channels; the checker beside the engine judges every reply.
// ----------------------------------------------------------------------------
module tb_top;
  import chse_pkg::*;

  localparam int BUCKETS      = BUCKETS_DEF;
  localparam int BUCKET_DEPTH = BUCKET_DEPTH_DEF;

  localparam logic [REQ_W-1:0] OP_RESERVED = 2'd3;

  localparam int QUIET_LIMIT = 3000;
  localparam int ROUNDS      = 3;
  localparam int PHASE_LEN   = 120;
  localparam int POOL_SIZE   = 40;

  typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} phase_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             calm;
  int               mismatches;
  int               awaiting;
  int               words_checked;
  int               refusals;
  int               quiet;
  int               op_count [4];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  chse_in_if  in_ch ();
  chse_out_if out_ch ();

  chained_hash_set_engine #(
    .BUCKETS      (BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  chse_checker #(
    .BUCKETS      (BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mismatches    (mismatches),
    .awaiting      (awaiting),
    .words_checked (words_checked),
    .refusals      (refusals)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_word(input logic [REQ_W-1:0] op, input logic [KEY_W-1:0] key);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= op;
    in_ch.key      <= key;
    op_count[op]++;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return KEY_W'($urandom());
  endfunction

  function automatic logic [REQ_W-1:0] pick_op(phase_t ph);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return OP_RESERVED;
    case (ph)
      PH_FILL: begin
        return (roll < 75) ? OP_INSERT : ((roll < 90) ? OP_SEARCH : OP_DELETE);
      end
      PH_MIXED: begin
        return (roll < 40) ? OP_INSERT : ((roll < 70) ? OP_SEARCH : OP_DELETE);
      end
      default: begin
        return (roll < 20) ? OP_INSERT : ((roll < 40) ? OP_SEARCH : OP_DELETE);
      end
    endcase
  endfunction

  initial begin
    rst_n          <= 1'b0;
    calm           <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= OP_INSERT;
    in_ch.key      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Bucket seven is filled to the brim, refuses one more key and then
    // accepts it again once a delete has made room.
    send_word(OP_SEARCH, 31'd0);
    send_word(OP_DELETE, 31'd0);
    send_word(OP_INSERT, 31'd0);
    send_word(OP_INSERT, 31'd2147483647);
    send_word(OP_INSERT, 31'd17);
    send_word(OP_INSERT, 31'd2147483647);
    send_word(OP_INSERT, 31'd27);
    send_word(OP_INSERT, 31'd7);
    send_word(OP_INSERT, 31'd2147483637);
    send_word(OP_INSERT, 31'd17);
    send_word(OP_INSERT, 31'd1431655767);
    send_word(OP_INSERT, 31'd1073741827);
    send_word(OP_SEARCH, 31'd2147483647);
    send_word(OP_RESERVED, 31'd17);
    send_word(OP_DELETE, 31'd17);
    send_word(OP_SEARCH, 31'd17);
    send_word(OP_INSERT, 31'd1073741827);
    send_word(OP_DELETE, 31'd0);
    send_word(OP_SEARCH, 31'd0);
    send_word(OP_DELETE, 31'd1073741824);
    send_word(OP_INSERT, 31'd715827882);
    send_word(OP_RESERVED, 31'd715827882);
    drain_results();

    for (int r = 0; r < ROUNDS; r++) begin
      for (int i = 0; i < POOL_SIZE; i++) begin
        key_pool[i] = (i < 8) ? KEY_W'($urandom_range(0, 99)) : KEY_W'($urandom());
      end
      for (int p = PH_FILL; p <= PH_DRAIN; p++) begin
        calm <= (r == 1 && p == PH_MIXED);
        for (int n = 0; n < PHASE_LEN; n++) send_word(pick_op(phase_t'(p)), pick_key());
        drain_results();
      end
    end

    repeat (48) @(posedge clk);
    $display("Sent %0d requests: %0d insert, %0d search, %0d delete, %0d reserved code.",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[OP_INSERT], op_count[OP_SEARCH], op_count[OP_DELETE],
             op_count[OP_RESERVED]);
    $display("Checked %0d result words, %0d of them refusals by a full bucket.",
             words_checked, refusals);
    if (mismatches == 0 && awaiting == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/chse_pkg.sv
rtl/chse_if.sv
rtl/chse_rem.sv
rtl/chained_hash_set_engine.sv
tb/chse_checker.sv
tb/tb_top.sv
